// ===== src/tsm_pkg.sv =====
// Package for the timing stability monitor.
// Holds the phase codes, field widths, defaults and the divider request type.
// No dependencies.
package tsm_pkg;

  // Phase codes as they appear on the result channel.
  localparam logic [2:0] PH_WARM = 3'd0;
  localparam logic [2:0] PH_DISC = 3'd1;
  localparam logic [2:0] PH_FILL = 3'd2;
  localparam logic [2:0] PH_KEEP = 3'd3;
  localparam logic [2:0] PH_FIN  = 3'd4;

  // Register indexes on the configuration port.
  localparam logic [1:0] REG_WARMUP = 2'd0;
  localparam logic [1:0] REG_MAX    = 2'd1;
  localparam logic [1:0] REG_LIMIT  = 2'd2;

  // Defaults selected by a written zero.
  localparam logic [31:0] DEF_WARMUP = 32'd10000000;
  localparam logic [31:0] DEF_MAX    = 32'd10000000;
  localparam logic [31:0] DEF_LIMIT  = 32'd655;

  // Divider geometry: 56-bit dividend, 40-bit divisor.
  localparam int DIVN_W = 56;
  localparam int DIVD_W = 40;

  // Packed result width: 236 bits of fields rounded up to whole bytes.
  localparam int OUT_W = 240;

  // Request from the sequencer to the serial divider.
  typedef struct packed {
    logic              start;
    logic [DIVN_W-1:0] dividend;
    logic [DIVD_W-1:0] divisor;
  } div_req_t;

endpackage

// ===== src/timing_stability_monitor_unit.sv =====
// Timing stability monitor: top level with sequencer, state and result register.
// Depends on tsm_pkg, tsm_ram and tsm_div.
//
// The monitor takes one run duration per transaction and returns one result per
// transaction. Warmup samples and samples after the stopping rule has fired go
// from the idle state straight to the output state. Discard samples add one
// serial division for the running mean. Fill and keep samples add three divisions
// (running mean, relative deviation unless the mean is zero, window mean) through
// one shared bit-serial divider, plus a read and a write of the deviation window
// RAM. One sample is processed at a time; the next sample can be taken while the
// previous result waits on the output. No clearing pass is needed after reset,
// since the window is written in full before a value read from it is used.
module timing_stability_monitor_unit import tsm_pkg::*; #(
  parameter int WINDOW = 100
) (
  input  logic             clk,
  input  logic             rst_n,
  // Input stream. tdata: sample_ticks[31:0].
  input  logic             in_tvalid,
  output logic             in_tready,
  input  logic [31:0]      in_tdata,
  // Result stream. tdata from bit 0: phase[2:0], done_res, sample_count[31:0],
  // total_ticks[47:0], average_ticks[39:0], mean_deviation[31:0],
  // warmup_count[31:0], warmup_total[47:0], 4 zero bits.
  output logic             out_tvalid,
  input  logic             out_tready,
  output logic [OUT_W-1:0] out_tdata,
  // Configuration write port.
  input  logic             cfg_we,
  input  logic [1:0]       cfg_addr,
  input  logic [31:0]      cfg_wdata
);

  localparam int PCW = $clog2(WINDOW + 1);
  localparam int PW  = (WINDOW > 1) ? $clog2(WINDOW) : 1;

  typedef enum logic [8:0] {
    S_IDLE      = 9'b000000001,
    S_MEAN_GO   = 9'b000000010,
    S_MEAN_WAIT = 9'b000000100,
    S_DEV_GO    = 9'b000001000,
    S_DEV_WAIT  = 9'b000010000,
    S_SUM       = 9'b000100000,
    S_WM_GO     = 9'b001000000,
    S_WM_WAIT   = 9'b010000000,
    S_OUT       = 9'b100000000
  } state_t;

  state_t           state_r, state_nxt;
  logic [31:0]      wup_r, wup_nxt, max_r, max_nxt, lim_r, lim_nxt;
  logic [2:0]       phase_r, phase_nxt;
  logic             done_r, done_nxt;
  logic [47:0]      run_total_r, run_total_nxt;
  logic [31:0]      run_count_r, run_count_nxt;
  logic [47:0]      warm_total_r, warm_total_nxt;
  logic [31:0]      warm_count_r, warm_count_nxt;
  logic [PCW-1:0]   pcnt_r, pcnt_nxt;
  logic [47:0]      dev_sum_r, dev_sum_nxt;
  logic [PW-1:0]    ptr_r, ptr_nxt;
  logic [39:0]      mean_r, mean_nxt;
  logic [31:0]      mdev_r, mdev_nxt;
  logic [31:0]      samp_r, samp_nxt;
  logic [31:0]      dev_r, dev_nxt;
  logic             op_dev_r, op_dev_nxt;
  logic             op_keep_r, op_keep_nxt;
  logic             out_valid_r, out_valid_nxt;
  logic [OUT_W-1:0] out_data_r, out_data_nxt;

  logic [48:0]      warm_sum, run_sum;
  logic [47:0]      warm_total_add, run_total_add;
  logic [31:0]      warm_count_inc, run_count_inc;
  logic [PCW-1:0]   pcnt_inc;
  logic [31:0]      wup_eff, max_eff, lim_eff;
  logic [39:0]      samp_q8, abs_diff;
  logic             ram_we, ram_re;
  logic [31:0]      ram_rdata;
  div_req_t         div_req;
  logic             div_done;
  logic [DIVN_W-1:0] div_quot;

  // Effective register values: zero selects the default.
  assign wup_eff = (wup_r == '0) ? DEF_WARMUP : wup_r;
  assign max_eff = (max_r == '0) ? DEF_MAX    : max_r;
  assign lim_eff = (lim_r == '0) ? DEF_LIMIT  : lim_r;

  // Saturating accumulators and counters; the phase counter is not saturated.
  assign warm_sum       = {1'b0, warm_total_r} + 49'(in_tdata);
  assign run_sum        = {1'b0, run_total_r} + 49'(in_tdata);
  assign warm_total_add = warm_sum[48] ? '1 : warm_sum[47:0];
  assign run_total_add  = run_sum[48] ? '1 : run_sum[47:0];
  assign warm_count_inc = (warm_count_r == '1) ? warm_count_r : warm_count_r + 1'b1;
  assign run_count_inc  = (run_count_r == '1) ? run_count_r : run_count_r + 1'b1;
  assign pcnt_inc       = pcnt_r + 1'b1;

  // Distance of the sample from the running mean, both in Q32.8.
  assign samp_q8  = {samp_r, 8'd0};
  assign abs_diff = (samp_q8 > mean_r) ? samp_q8 - mean_r : mean_r - samp_q8;

  assign in_tready = (state_r == S_IDLE);

  // Sequencer and state update.
  always_comb begin
    state_nxt      = state_r;
    phase_nxt      = phase_r;
    done_nxt       = done_r;
    run_total_nxt  = run_total_r;
    run_count_nxt  = run_count_r;
    warm_total_nxt = warm_total_r;
    warm_count_nxt = warm_count_r;
    pcnt_nxt       = pcnt_r;
    dev_sum_nxt    = dev_sum_r;
    ptr_nxt        = ptr_r;
    mean_nxt       = mean_r;
    mdev_nxt       = mdev_r;
    samp_nxt       = samp_r;
    dev_nxt        = dev_r;
    op_dev_nxt     = op_dev_r;
    op_keep_nxt    = op_keep_r;
    out_valid_nxt  = out_valid_r && !out_tready;
    out_data_nxt   = out_data_r;
    ram_we         = 1'b0;
    ram_re         = 1'b0;
    div_req        = '0;

    case (state_r)
      S_IDLE: begin
        if (in_tvalid) begin
          samp_nxt    = in_tdata;
          op_dev_nxt  = 1'b0;
          op_keep_nxt = 1'b0;
          case (phase_r)
            PH_WARM: begin
              warm_total_nxt = warm_total_add;
              warm_count_nxt = warm_count_inc;
              if (warm_total_add >= {16'd0, wup_eff}) begin
                phase_nxt = PH_DISC;
                pcnt_nxt  = '0;
              end
              state_nxt = S_OUT;
            end
            PH_DISC, PH_FILL: begin
              run_total_nxt = run_total_add;
              run_count_nxt = run_count_inc;
              op_dev_nxt    = (phase_r == PH_FILL);
              pcnt_nxt      = pcnt_inc;
              if (pcnt_inc == PCW'(WINDOW)) begin
                phase_nxt = (phase_r == PH_FILL) ? PH_KEEP : PH_FILL;
                pcnt_nxt  = '0;
              end
              state_nxt = S_MEAN_GO;
            end
            PH_KEEP: begin
              run_total_nxt = run_total_add;
              run_count_nxt = run_count_inc;
              op_dev_nxt    = 1'b1;
              op_keep_nxt   = 1'b1;
              state_nxt     = S_MEAN_GO;
            end
            default: begin
              state_nxt = S_OUT;
            end
          endcase
        end
      end
      S_MEAN_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {run_total_r, 8'd0};
        div_req.divisor  = {8'd0, run_count_r};
        state_nxt        = S_MEAN_WAIT;
      end
      S_MEAN_WAIT: begin
        if (div_done) begin
          mean_nxt  = (div_quot[DIVN_W-1:40] != '0) ? '1 : div_quot[39:0];
          state_nxt = op_dev_r ? S_DEV_GO : S_OUT;
        end
      end
      S_DEV_GO: begin
        // Fetch the oldest window entry while the deviation is worked out.
        ram_re = 1'b1;
        if (mean_r == '0) begin
          dev_nxt   = (samp_r == '0) ? '0 : '1;
          state_nxt = S_SUM;
        end else begin
          div_req.start    = 1'b1;
          div_req.dividend = {abs_diff, 16'd0};
          div_req.divisor  = mean_r;
          state_nxt        = S_DEV_WAIT;
        end
      end
      S_DEV_WAIT: begin
        if (div_done) begin
          dev_nxt   = (div_quot[DIVN_W-1:32] != '0) ? '1 : div_quot[31:0];
          state_nxt = S_SUM;
        end
      end
      S_SUM: begin
        // Replace the oldest deviation in the window and its running sum.
        ram_we      = 1'b1;
        dev_sum_nxt = dev_sum_r - (op_keep_r ? 48'(ram_rdata) : 48'd0) + 48'(dev_r);
        ptr_nxt     = (ptr_r == PW'(WINDOW - 1)) ? '0 : ptr_r + 1'b1;
        state_nxt   = S_WM_GO;
      end
      S_WM_GO: begin
        div_req.start    = 1'b1;
        div_req.dividend = {8'd0, dev_sum_r};
        div_req.divisor  = (phase_r == PH_KEEP) ? DIVD_W'(WINDOW) : DIVD_W'(pcnt_r);
        state_nxt        = S_WM_WAIT;
      end
      S_WM_WAIT: begin
        if (div_done) begin
          mdev_nxt = div_quot[31:0];
          if (op_keep_r && ((div_quot[31:0] <= lim_eff) ||
                            (run_total_r >= {16'd0, max_eff}))) begin
            phase_nxt = PH_FIN;
            done_nxt  = 1'b1;
          end
          state_nxt = S_OUT;
        end
      end
      S_OUT: begin
        if (!out_valid_r || out_tready) begin
          out_data_nxt  = {4'd0, warm_total_r, warm_count_r, mdev_r, mean_r,
                           run_total_r, run_count_r, done_r, phase_r};
          out_valid_nxt = 1'b1;
          state_nxt     = S_IDLE;
        end
      end
      default: begin
        state_nxt = S_IDLE;
      end
    endcase
  end

  // Configuration registers.
  always_comb begin
    wup_nxt = wup_r;
    max_nxt = max_r;
    lim_nxt = lim_r;
    if (cfg_we) begin
      case (cfg_addr)
        REG_WARMUP: wup_nxt = cfg_wdata;
        REG_MAX:    max_nxt = cfg_wdata;
        REG_LIMIT:  lim_nxt = cfg_wdata;
        default:    ;
      endcase
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r      <= S_IDLE;
      wup_r        <= DEF_WARMUP;
      max_r        <= DEF_MAX;
      lim_r        <= DEF_LIMIT;
      phase_r      <= PH_WARM;
      done_r       <= 1'b0;
      run_total_r  <= '0;
      run_count_r  <= '0;
      warm_total_r <= '0;
      warm_count_r <= '0;
      pcnt_r       <= '0;
      dev_sum_r    <= '0;
      ptr_r        <= '0;
      mean_r       <= '0;
      mdev_r       <= '0;
      out_valid_r  <= 1'b0;
    end else begin
      state_r      <= state_nxt;
      wup_r        <= wup_nxt;
      max_r        <= max_nxt;
      lim_r        <= lim_nxt;
      phase_r      <= phase_nxt;
      done_r       <= done_nxt;
      run_total_r  <= run_total_nxt;
      run_count_r  <= run_count_nxt;
      warm_total_r <= warm_total_nxt;
      warm_count_r <= warm_count_nxt;
      pcnt_r       <= pcnt_nxt;
      dev_sum_r    <= dev_sum_nxt;
      ptr_r        <= ptr_nxt;
      mean_r       <= mean_nxt;
      mdev_r       <= mdev_nxt;
      out_valid_r  <= out_valid_nxt;
    end
    samp_r     <= samp_nxt;
    dev_r      <= dev_nxt;
    op_dev_r   <= op_dev_nxt;
    op_keep_r  <= op_keep_nxt;
    out_data_r <= out_data_nxt;
  end

  assign out_tvalid = out_valid_r;
  assign out_tdata  = out_data_r;

  // Deviation window.
  tsm_ram #(.WIDTH(32), .DEPTH(WINDOW)) u_window (
    .clk   (clk),
    .we    (ram_we),
    .waddr (ptr_r),
    .wdata (dev_r),
    .re    (ram_re),
    .raddr (ptr_r),
    .rdata (ram_rdata)
  );

  // Shared serial divider.
  tsm_div u_div (
    .clk   (clk),
    .rst_n (rst_n),
    .req   (div_req),
    .done  (div_done),
    .quot  (div_quot)
  );

  // Checks on the sequencer.
  a_done_fin: assert property (@(posedge clk) disable iff (!rst_n)
    done_r |-> (phase_r == PH_FIN))
    else $error("done set outside the finished phase");

  a_div_wait: assert property (@(posedge clk) disable iff (!rst_n)
    div_done |-> (state_r == S_MEAN_WAIT || state_r == S_DEV_WAIT ||
                  state_r == S_WM_WAIT))
    else $error("divider finished while no division was awaited");

  a_pcnt_range: assert property (@(posedge clk) disable iff (!rst_n)
    pcnt_r < PCW'(WINDOW))
    else $error("phase counter beyond the window");

  a_accept_busy: assert property (@(posedge clk) disable iff (!rst_n)
    (in_tvalid && in_tready) |=> (state_r != S_IDLE))
    else $error("accepted transaction was not processed");

endmodule

// ===== src/tsm_ram.sv =====
// Generic single-write, single-read RAM with a registered read port.
// Depends on nothing.
module tsm_ram #(
  parameter int WIDTH = 32,
  parameter int DEPTH = 100
) (
  input  logic                                clk,
  input  logic                                we,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] waddr,
  input  logic [WIDTH-1:0]                    wdata,
  input  logic                                re,
  input  logic [(DEPTH > 1 ? $clog2(DEPTH) : 1)-1:0] raddr,
  output logic [WIDTH-1:0]                    rdata
);

  logic [WIDTH-1:0] mem_r [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  // Write port and registered read port.
  always_ff @(posedge clk) begin
    if (we) begin
      mem_r[waddr] <= wdata;
    end
    if (re) begin
      rdata_r <= mem_r[raddr];
    end
  end

  assign rdata = rdata_r;

endmodule

// ===== src/tsm_div.sv =====
// Bit-serial restoring divider, one quotient bit per cycle.
// Depends on tsm_pkg for the operand widths and the request type.
module tsm_div import tsm_pkg::*; (
  input  logic              clk,
  input  logic              rst_n,
  input  div_req_t          req,
  output logic              done,
  output logic [DIVN_W-1:0] quot
);

  localparam int CNT_W = $clog2(DIVN_W + 1);

  logic              busy_r, busy_nxt;
  logic              done_r, done_nxt;
  logic [CNT_W-1:0]  cnt_r, cnt_nxt;
  logic [DIVD_W-1:0] rem_r, rem_nxt;
  logic [DIVN_W-1:0] q_r, q_nxt;
  logic [DIVD_W-1:0] dvs_r, dvs_nxt;
  logic [DIVD_W:0]   trial;
  logic [DIVD_W:0]   diff;
  logic              ge;

  // One restoring step: bring down the next dividend bit and try a subtract.
  assign trial = {rem_r, q_r[DIVN_W-1]};
  assign diff  = trial - {1'b0, dvs_r};
  assign ge    = trial >= {1'b0, dvs_r};

  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt  = cnt_r;
    rem_nxt  = rem_r;
    q_nxt    = q_r;
    dvs_nxt  = dvs_r;
    if (req.start) begin
      busy_nxt = 1'b1;
      cnt_nxt  = CNT_W'(DIVN_W);
      rem_nxt  = '0;
      q_nxt    = req.dividend;
      dvs_nxt  = req.divisor;
    end else if (busy_r) begin
      rem_nxt = ge ? diff[DIVD_W-1:0] : trial[DIVD_W-1:0];
      q_nxt   = {q_r[DIVN_W-2:0], ge};
      cnt_nxt = cnt_r - 1'b1;
      if (cnt_r == CNT_W'(1)) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r  <= '0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r  <= cnt_nxt;
    end
    rem_r <= rem_nxt;
    q_r   <= q_nxt;
    dvs_r <= dvs_nxt;
  end

  assign done = done_r;
  assign quot = q_r;

endmodule
